FILE: design/pidrd_pkg.sv
// Shared types, constants and arithmetic helpers of the PID controller with ramp and deadband.
// Used by pidrd_ctrl, pidrd_dp and pid_controller_ramp_deadband.
// It depends on nothing else.
package pidrd_pkg;

	// Fixed-point format of every data value.
	localparam int DW = 32;
	localparam int FB = 16;
	// Multiplier operand and product widths, and the width of the widest sum.
	localparam int AW = 33;
	localparam int BW = 35;
	localparam int PW = AW + BW;
	localparam int SW = DW + 3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_KP    = 3'd0;
	localparam logic [2:0] CFG_KI    = 3'd1;
	localparam logic [2:0] CFG_KD    = 3'd2;
	localparam logic [2:0] CFG_ALPHA = 3'd3;
	localparam logic [2:0] CFG_LIM   = 3'd4;
	localparam logic [2:0] CFG_DB    = 3'd5;
	localparam logic [2:0] CFG_STEP  = 3'd6;
	localparam logic [2:0] CFG_MODE  = 3'd7;

	// Setpoint write codes and opcodes.
	localparam logic [1:0] WR_TGT = 2'd1;
	localparam logic [1:0] WR_CUR = 2'd2;
	localparam logic OP_CLEAR = 1'b1;

	// Mode register bits.
	localparam int MODE_RAMP = 0;
	localparam int MODE_VEL  = 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SETP, ST_ERR, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_FIN
	} state_t;

	// Which product the shared multiplier forms.
	typedef enum logic [2:0] {
		MUL_NONE, MUL_KP_E, MUL_KP_DE, MUL_KI_SE, MUL_KD_DE, MUL_KD_DDE, MUL_AL_DF
	} mul_sel_t;

	// Where the scaled product goes.
	typedef enum logic [2:0] {
		NRM_NONE, NRM_T1, NRM_T2, NRM_T3, NRM_DF
	} nrm_t;

	typedef struct packed {
		logic     load;
		logic     setp;
		logic     err;
		mul_sel_t mul;
		nrm_t     nrm;
		logic     integ_upd;
		logic     fin;
	} cmd_t;

	typedef struct packed {
		logic clr;
		logic vel;
		logic out_busy;
	} sts_t;

	// Saturate a wide sum to the data range.
	function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
		lo = ~hi;
		if (x > hi) return hi[DW-1:0];
		else if (x < lo) return lo[DW-1:0];
		else return x[DW-1:0];
	endfunction

	// Clamp a wide sum to plus or minus a non-negative limit.
	function automatic logic signed [DW-1:0] clamp_sym(input logic signed [SW-1:0] x,
		input logic [DW-2:0] lim);
		logic signed [SW-1:0] lp;
		logic signed [SW-1:0] ln;
		lp = {{(SW-DW+1){1'b0}}, lim};
		ln = -lp;
		if (x > lp) return lp[DW-1:0];
		else if (x < ln) return ln[DW-1:0];
		else return x[DW-1:0];
	endfunction

	// Scale a product down by FB or FB+1 bits toward zero, then saturate.
	function automatic logic signed [DW-1:0] scale_prod(input logic signed [PW-1:0] p,
		input logic sh_one);
		logic signed [PW-1:0] bias;
		logic signed [PW-1:0] b;
		logic signed [PW-1:0] q;
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		bias = sh_one ? {{(PW-FB-1){1'b0}}, {(FB+1){1'b1}}} : {{(PW-FB){1'b0}}, {FB{1'b1}}};
		b = p[PW-1] ? p + bias : p;
		q = sh_one ? (b >>> (FB + 1)) : (b >>> FB);
		hi = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
		lo = ~hi;
		if (q > hi) return hi[DW-1:0];
		else if (q < lo) return lo[DW-1:0];
		else return q[DW-1:0];
	endfunction

endpackage

FILE: design/pid_controller_ramp_deadband.sv
// Top level of the fixed-point PID controller with setpoint ramp and error deadband.
// Joins the sequencer pidrd_ctrl and the datapath pidrd_dp; types come from pidrd_pkg.
//
//  channel  | direction | handshake          | content
//  s_*      | in        | s_tvalid/s_tready  | one sample word and setpoint command
//  m_*      | out       | m_tvalid/m_tready  | drive, error, setpoint and saturation flag
//  cfg_*    | in        | cfg_we             | gain, limit, deadband, ramp and mode registers
//
// A control step runs from acceptance through the setpoint, error and product steps to
// the result register; velocity form skips the two derivative-filter steps and a clear
// goes from the setpoint step straight to the result. The single shared multiplier,
// one product per cycle, sets the number of product steps. One word is in work at a
// time; the next is taken once the result sits in the output register, even while it
// waits. A stalled output holds the sequencer in its last step. Reset is asynchronous
// and clears all loop state and loads the register defaults.
module pid_controller_ramp_deadband
	import pidrd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_addr,
	input  logic [DW-1:0] cfg_wdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [63:0]   s_tdata,   // feedback, setpoint_value
	input  logic [2:0]    s_tuser,   // opcode, setpoint_write
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [95:0]   m_tdata,   // drive, error_now, setpoint_now
	output logic          m_tuser    // saturated
);

	cmd_t cmd;
	sts_t sts;

	pidrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pidrd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: design/pidrd_ctrl.sv
// Sequencer of the PID controller: steps one word through setpoint, error and products.
// Depends on pidrd_pkg for the state, command and status types.
module pidrd_ctrl
	import pidrd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_SETP;
			end
			ST_SETP: begin
				state_d = sts.clr ? ST_FIN : ST_ERR;
			end
			ST_ERR: state_d = ST_P1;
			ST_P1:  state_d = ST_P2;
			ST_P2:  state_d = ST_P3;
			ST_P3:  state_d = ST_P4;
			ST_P4:  state_d = sts.vel ? ST_FIN : ST_P5;
			ST_P5:  state_d = ST_P6;
			ST_P6:  state_d = ST_FIN;
			ST_FIN: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		cmd.mul = MUL_NONE;
		cmd.nrm = NRM_NONE;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_SETP: cmd.setp = 1'b1;
			ST_ERR:  cmd.err = 1'b1;
			ST_P1:   cmd.mul = sts.vel ? MUL_KP_DE : MUL_KP_E;
			ST_P2: begin
				cmd.nrm = NRM_T1;
				cmd.mul = MUL_KI_SE;
			end
			ST_P3: begin
				cmd.nrm = NRM_T2;
				cmd.mul = sts.vel ? MUL_KD_DDE : MUL_KD_DE;
			end
			ST_P4: begin
				cmd.nrm = NRM_T3;
				cmd.integ_upd = !sts.vel;
			end
			ST_P5:  cmd.mul = MUL_AL_DF;
			ST_P6:  cmd.nrm = NRM_DF;
			ST_FIN: cmd.fin = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: design/pidrd_dp.sv
// Datapath of the PID controller: configuration, loop state, shared multiplier and result word.
// Depends on pidrd_pkg for widths, command types and the fixed-point helpers.
module pidrd_dp
	import pidrd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_addr,
	input  logic [DW-1:0] cfg_wdata,
	input  logic [63:0]   s_tdata,
	input  logic [2:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [95:0]   m_tdata,
	output logic          m_tuser,
	input  cmd_t          cmd,
	output sts_t          sts
);

	// Configuration registers.
	logic signed [DW-1:0] kp_q, ki_q, kd_q;
	logic [16:0]          alpha_q;
	logic [DW-2:0]        lim_q, db_q, step_q;
	logic [1:0]           mode_q;

	// Latched input word.
	logic                 op_q;
	logic [1:0]           wr_q;
	logic signed [DW-1:0] fb_q, val_q;

	// Loop state and scratch terms.
	logic signed [DW-1:0] sp_cur_q, sp_tgt_q, e1_q, e2_q, integ_q, df_q, acc_q;
	logic signed [DW-1:0] e_q, t1_q, t2_q, t3_q;
	logic signed [PW-1:0] prod_q;
	logic                 sh_q;

	// Result register.
	logic                 m_tvalid_q;
	logic signed [DW-1:0] drive_q, err_out_q, sp_out_q;
	logic                 sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			ki_q    <= '0;
			kd_q    <= '0;
			alpha_q <= 17'h10000;
			lim_q   <= '1;
			db_q    <= '0;
			step_q  <= '0;
			mode_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_KP:    kp_q    <= cfg_wdata;
				CFG_KI:    ki_q    <= cfg_wdata;
				CFG_KD:    kd_q    <= cfg_wdata;
				CFG_ALPHA: alpha_q <= cfg_wdata[16:0];
				CFG_LIM:   lim_q   <= cfg_wdata[DW-2:0];
				CFG_DB:    db_q    <= cfg_wdata[DW-2:0];
				CFG_STEP:  step_q  <= cfg_wdata[DW-2:0];
				CFG_MODE:  mode_q  <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Setpoint writes and ramp.
	logic signed [DW-1:0] cur_w, tgt_w, ramp_w;
	logic signed [SW-1:0] up_w, dn_w;
	always_comb begin
		cur_w = (wr_q == WR_CUR) ? val_q : sp_cur_q;
		tgt_w = (wr_q == WR_TGT) ? val_q : sp_tgt_q;
		up_w = SW'(cur_w) + SW'($signed({1'b0, step_q}));
		dn_w = SW'(cur_w) - SW'($signed({1'b0, step_q}));
		if (op_q == OP_CLEAR || !mode_q[MODE_RAMP]) ramp_w = cur_w;
		else if (SW'(tgt_w) > up_w) ramp_w = up_w[DW-1:0];
		else if (SW'(tgt_w) < dn_w) ramp_w = dn_w[DW-1:0];
		else ramp_w = tgt_w;
	end

	// Error with deadband.
	logic signed [DW-1:0] es_w, e_w;
	logic [DW-1:0]        mag_w;
	always_comb begin
		es_w = sat_dw(SW'(sp_cur_q) - SW'(fb_q));
		mag_w = es_w[DW-1] ? (~es_w + 1'b1) : es_w;
		e_w = (mag_w < {1'b0, db_q}) ? '0 : es_w;
	end

	// Operand selection for the shared multiplier.
	logic signed [AW-1:0] a_w;
	logic signed [BW-1:0] b_w;
	always_comb begin
		a_w = '0;
		b_w = '0;
		case (cmd.mul)
			MUL_KP_E: begin
				a_w = AW'(kp_q);
				b_w = BW'(e_q);
			end
			MUL_KP_DE: begin
				a_w = AW'(kp_q);
				b_w = BW'(e_q) - BW'(e1_q);
			end
			MUL_KI_SE: begin
				a_w = AW'(ki_q);
				b_w = BW'(e_q) + BW'(e1_q);
			end
			MUL_KD_DE: begin
				a_w = AW'(kd_q);
				b_w = BW'(e_q) - BW'(e1_q);
			end
			MUL_KD_DDE: begin
				a_w = AW'(kd_q);
				b_w = BW'(e_q) - (BW'(e1_q) <<< 1) + BW'(e2_q);
			end
			MUL_AL_DF: begin
				a_w = $signed({{(AW-17){1'b0}}, alpha_q});
				b_w = BW'(t3_q) - BW'(df_q);
			end
			default: begin
				a_w = '0;
				b_w = '0;
			end
		endcase
	end

	logic signed [DW-1:0] nv_w;
	assign nv_w = scale_prod(prod_q, sh_q);

	// Final sum and output clamp.
	logic signed [SW-1:0] sum_w, lim_s;
	logic signed [DW-1:0] res_w;
	logic                 hit_w;
	always_comb begin
		if (mode_q[MODE_VEL]) sum_w = SW'(acc_q) + SW'(t1_q) + SW'(t2_q) + SW'(t3_q);
		else sum_w = SW'(t1_q) + SW'(integ_q) + SW'(df_q);
		lim_s = $signed({{(SW-DW+1){1'b0}}, lim_q});
		res_w = clamp_sym(sum_w, lim_q);
		hit_w = (sum_w > lim_s) || (sum_w < -lim_s);
	end

	// Loop state and pipeline registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_cur_q <= '0;
			sp_tgt_q <= '0;
			e1_q     <= '0;
			e2_q     <= '0;
			integ_q  <= '0;
			df_q     <= '0;
			acc_q    <= '0;
		end else begin
			if (cmd.setp) begin
				sp_tgt_q <= tgt_w;
				sp_cur_q <= ramp_w;
			end
			if (cmd.integ_upd) integ_q <= clamp_sym(SW'(integ_q) + SW'(t2_q), lim_q);
			if (cmd.nrm == NRM_DF) df_q <= clamp_sym(SW'(df_q) + SW'(nv_w), lim_q >> 1);
			if (cmd.fin) begin
				if (op_q == OP_CLEAR) begin
					e1_q    <= '0;
					e2_q    <= '0;
					integ_q <= '0;
					df_q    <= '0;
					acc_q   <= '0;
				end else begin
					acc_q <= res_w;
					e2_q  <= e1_q;
					e1_q  <= e_q;
				end
			end
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fb_q  <= s_tdata[31:0];
			val_q <= s_tdata[63:32];
			op_q  <= s_tuser[0];
			wr_q  <= s_tuser[2:1];
		end
		if (cmd.setp) e_q <= '0;
		if (cmd.err) e_q <= e_w;
		if (cmd.mul != MUL_NONE) begin
			prod_q <= PW'(a_w) * PW'(b_w);
			sh_q   <= (cmd.mul == MUL_KI_SE);
		end
		case (cmd.nrm)
			NRM_T1: t1_q <= nv_w;
			NRM_T2: t2_q <= nv_w;
			NRM_T3: t3_q <= nv_w;
			default: ;
		endcase
		if (cmd.fin) begin
			sp_out_q  <= sp_cur_q;
			err_out_q <= (op_q == OP_CLEAR) ? '0 : e_q;
			drive_q   <= (op_q == OP_CLEAR) ? '0 : res_w;
			sat_q     <= (op_q == OP_CLEAR) ? 1'b0 : hit_w;
		end
	end

	// Output word valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.fin) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {sp_out_q, err_out_q, drive_q};
	assign m_tuser  = sat_q;

	assign sts.clr      = (op_q == OP_CLEAR);
	assign sts.vel      = mode_q[MODE_VEL];
	assign sts.out_busy = m_tvalid_q && !m_tready;

	// The integral stays within the limit after its update.
	a_integ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.integ_upd |=> (integ_q <= $signed({1'b0, lim_q})) &&
		(integ_q >= -$signed({1'b0, lim_q})))
		else $error("integral outside limit");

	// The filtered derivative stays within half the limit after its update.
	a_df_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.nrm == NRM_DF) |=> (df_q <= $signed({2'b0, lim_q[DW-2:1]})) &&
		(df_q >= -$signed({2'b0, lim_q[DW-2:1]})))
		else $error("derivative outside half limit");

	// A saturated result drives exactly plus or minus the limit.
	a_sat_drive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> !sat_q || (drive_q == $signed({1'b0, lim_q})) ||
		(drive_q == -$signed({1'b0, lim_q})))
		else $error("saturated flag without clamped drive");

	// A result is only produced when the output register is free.
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !(m_tvalid_q && !m_tready))
		else $error("result overwritten");

endmodule

FILE: sim/pid_controller_ramp_deadband_tb.sv
// Self-checking testbench for the ramped, deadbanded fixed-point PID controller.
// A behavioral predictor tracks loop state and configuration; depends on pidrd_pkg and the RTL.
`timescale 1ns / 100ps

module pid_controller_ramp_deadband_tb;
	import pidrd_pkg::*;

	localparam longint DMAX = 64'sd2147483647;
	localparam longint DMIN = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 300;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic signed [31:0] drive;
		logic signed [31:0] err;
		logic signed [31:0] setp;
		logic               sat;
	} pid_out_t;

	typedef struct {
		int          cfg_set;   // configuration set applied before the word, -1 for none
		logic        op;
		logic [31:0] fb;
		logic [1:0]  wr;
		logic [31:0] val;
		logic        typed;     // expected result given in the row
		pid_out_t    res;
	} vec_t;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [2:0]    cfg_addr;
	logic [31:0]   cfg_wdata;
	logic          s_tvalid;
	logic          s_tready;
	logic [63:0]   s_tdata;   // feedback, setpoint_value
	logic [2:0]    s_tuser;   // opcode, setpoint_write
	logic          m_tvalid;
	logic          m_tready;
	logic [95:0]   m_tdata;   // drive, error_now, setpoint_now
	logic          m_tuser;   // saturated

	pid_controller_ramp_deadband dut (.*);

	// Predictor copy of the registers and the loop state.
	longint kp, ki, kd, alpha, lim_reg, deadband, step_reg;
	logic [1:0] mode;
	longint sp_cur, sp_tgt, e1, e2, integ, dfilt, out_acc;

	pid_out_t drive_q[$];
	int errors = 0;
	int checked = 0;
	int clears = 0;
	int sat_seen = 0;
	int cycles = 0;
	bit calm = 0;
	bit hold_req = 0;
	int hold_cnt = 0;

	// Clock and cycle limit.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("pid_controller_ramp_deadband regression: fail");
			$finish;
		end
	end

	function automatic longint sat_data(longint x);
		if (x > DMAX) return DMAX;
		if (x < DMIN) return DMIN;
		return x;
	endfunction

	function automatic longint clamp_lim(longint x, longint l);
		if (x > l) return l;
		if (x < -l) return -l;
		return x;
	endfunction

	// Exact product scaled down toward zero, then saturated.
	function automatic longint qmul(longint a, longint b, int sh);
		logic signed [127:0] p;
		logic signed [127:0] mag;
		p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
		mag = (p < 0) ? -p : p;
		mag = mag >>> sh;
		if (p < 0) begin
			if (mag > 128'sd2147483648) mag = 128'sd2147483648;
			return -longint'(mag);
		end
		if (mag > 128'sd2147483647) mag = 128'sd2147483647;
		return longint'(mag);
	endfunction

	task automatic set_reg(input logic [2:0] idx, input logic [31:0] v);
		case (idx)
			CFG_KP:    kp = longint'($signed(v));
			CFG_KI:    ki = longint'($signed(v));
			CFG_KD:    kd = longint'($signed(v));
			CFG_ALPHA: alpha = longint'(v[16:0]);
			CFG_LIM:   lim_reg = longint'(v[30:0]);
			CFG_DB:    deadband = longint'(v[30:0]);
			CFG_STEP:  step_reg = longint'(v[30:0]);
			default:   mode = v[1:0];
		endcase
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	// One control step or clear of the predicted loop.
	task automatic pid_predict(input logic op, input logic [31:0] fb_in, input logic [1:0] wr,
		input logic [31:0] val_in, output pid_out_t r);
		longint fb, e, p, raw, d, hi, lo;
		bit hit;
		fb = longint'($signed(fb_in));
		e = 0;
		hit = 0;
		if (wr == WR_TGT) sp_tgt = longint'($signed(val_in));
		else if (wr == WR_CUR) sp_cur = longint'($signed(val_in));
		if (op == OP_CLEAR) begin
			e1 = 0; e2 = 0; integ = 0; dfilt = 0; out_acc = 0;
		end else begin
			if (mode[MODE_RAMP]) begin
				hi = sp_cur + step_reg;
				lo = sp_cur - step_reg;
				if (sp_tgt > hi) sp_cur = hi;
				else if (sp_tgt < lo) sp_cur = lo;
				else sp_cur = sp_tgt;
			end
			e = sat_data(sp_cur - fb);
			if (((e < 0) ? -e : e) < deadband) e = 0;
			if (mode[MODE_VEL]) begin
				d = qmul(kp, e - e1, FB) + qmul(ki, e + e1, FB + 1)
					+ qmul(kd, e - 2 * e1 + e2, FB);
				d = out_acc + d;
				hit = (d > lim_reg) || (d < -lim_reg);
				out_acc = clamp_lim(d, lim_reg);
			end else begin
				p = qmul(kp, e, FB);
				integ = clamp_lim(integ + qmul(ki, e + e1, FB + 1), lim_reg);
				raw = qmul(kd, e - e1, FB);
				dfilt = clamp_lim(dfilt + qmul(alpha, raw - dfilt, 16), lim_reg / 2);
				d = p + integ + dfilt;
				hit = (d > lim_reg) || (d < -lim_reg);
				out_acc = clamp_lim(d, lim_reg);
			end
			e2 = e1;
			e1 = e;
		end
		r.drive = (op == OP_CLEAR) ? 32'sd0 : out_acc[31:0];
		r.err = e[31:0];
		r.setp = sp_cur[31:0];
		r.sat = hit;
	endtask

	// Offer one word, wait for acceptance, record the expectation.
	task automatic send_word(input logic op, input logic [31:0] fb, input logic [1:0] wr,
		input logic [31:0] val, input logic typed, input pid_out_t given);
		pid_out_t r;
		s_tvalid <= 1'b1;
		s_tdata <= {val, fb};
		s_tuser <= {wr, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pid_predict(op, fb, wr, val, r);
		if (op == OP_CLEAR) clears++;
		drive_q.push_back(typed ? given : r);
		if (!calm && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Registers are only written once the block has delivered everything.
	task automatic write_set(input logic [31:0] regs[8]);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (drive_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		for (int i = 0; i < 8; i++) set_reg(3'(i), regs[i]);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rnd_gain();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h30000)) - 32'sh18000);
		endcase
	endfunction

	function automatic logic [31:0] rnd_q(input logic [31:0] span);
		return ($urandom_range(3) == 0) ? $urandom : ($urandom_range(0, span) - span / 2);
	endfunction

	// Output side: random stalls, one long hold-off, checking of each word.
	always @(posedge clk) begin
		pid_out_t x;
		if (arst_n && m_tvalid && m_tready) begin
			if (drive_q.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, m_tdata);
				errors++;
			end else begin
				x = drive_q.pop_front();
				checked++;
				if (m_tuser) sat_seen++;
				if (m_tdata[31:0] !== x.drive) begin
					$display("%0t: drive expected %h actual %h", $time, x.drive, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== x.err) begin
					$display("%0t: error_now expected %h actual %h", $time, x.err,
						m_tdata[63:32]);
					errors++;
				end
				if (m_tdata[95:64] !== x.setp) begin
					$display("%0t: setpoint_now expected %h actual %h", $time, x.setp,
						m_tdata[95:64]);
					errors++;
				end
				if (m_tuser !== x.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, x.sat, m_tuser);
					errors++;
				end
			end
		end
		if (hold_req && hold_cnt == 0) begin
			hold_cnt <= HOLD_CYCLES;
			hold_req <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
		m_tready <= (hold_req || hold_cnt > 1) ? 1'b0 : (calm || $urandom_range(99) >= 12);
	end

	// Directed table and its configuration sets.
	logic [31:0] cfg_sets[3][8];
	vec_t dir_tab[$];

	function automatic vec_t row(int cs, logic op, logic [31:0] fb, logic [1:0] wr,
		logic [31:0] val, logic typed, logic [31:0] dr, logic [31:0] er, logic [31:0] sp,
		logic st);
		vec_t v;
		v.cfg_set = cs; v.op = op; v.fb = fb; v.wr = wr; v.val = val; v.typed = typed;
		v.res.drive = dr; v.res.err = er; v.res.setp = sp; v.res.sat = st;
		return v;
	endfunction

	initial begin
		logic [31:0] regs[8];
		logic [31:0] sp_hint;
		logic [1:0] wr;
		cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
		kp = 0; ki = 0; kd = 0; alpha = 65536; lim_reg = 32'h7FFF_FFFF;
		deadband = 0; step_reg = 0; mode = 2'b00;
		sp_cur = 0; sp_tgt = 0; e1 = 0; e2 = 0; integ = 0; dfilt = 0; out_acc = 0;

		// Ramp on, small limit, deadband; then velocity form; then extreme gains.
		cfg_sets[0] = '{32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0000_8000,
			32'h0002_0000, 32'h0000_0100, 32'h0000_8000, 32'h1};
		cfg_sets[1] = '{32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0,
			32'h0, 32'h0, 32'h7FFF_FFFF, 32'h3};
		cfg_sets[2] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h2};

		// Reset defaults: zero gains, so drive stays zero and the error is plain.
		dir_tab.push_back(row(-1, 0, 32'h0, 0, 32'h0, 1, 0, 0, 0, 0));
		dir_tab.push_back(row(-1, 0, 32'h8000_0000, WR_CUR, 32'h7FFF_FFFF, 1,
			0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		dir_tab.push_back(row(-1, 0, 32'h7FFF_FFFF, WR_CUR, 32'h8000_0000, 1,
			0, 32'h8000_0000, 32'h8000_0000, 0));
		dir_tab.push_back(row(-1, OP_CLEAR, 32'hFFFF_FFFF, WR_CUR, 32'h0001_2345, 1,
			0, 0, 32'h0001_2345, 0));
		dir_tab.push_back(row(-1, 0, 32'h0001_0000, WR_TGT, 32'h0005_0000, 1,
			0, 32'h0000_2345, 32'h0001_2345, 0));
		dir_tab.push_back(row(-1, 0, 32'h0, 2'd3, 32'hDEAD_BEEF, 1,
			0, 32'h0001_2345, 32'h0001_2345, 0));
		dir_tab.push_back(row(-1, OP_CLEAR, 32'h0, WR_TGT, 32'h0, 1,
			0, 0, 32'h0001_2345, 0));
		// Ramp toward a written target, deadband edge, saturation.
		dir_tab.push_back(row(0, 0, 32'h0, WR_TGT, 32'h0004_0000, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(-1, 0, 32'h0, 0, 32'h0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(-1, 0, 32'h0000_0000, WR_CUR, 32'h0000_00FF, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(-1, 0, 32'hFFFF_FF00, WR_TGT, 32'h0000_0000, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(-1, 0, 32'h8000_0000, WR_TGT, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(-1, OP_CLEAR, 32'h0, 0, 32'h0, 0, 0, 0, 0, 0));
		// Velocity form at limit zero and largest ramp step.
		dir_tab.push_back(row(1, 0, 32'h0001_0000, WR_TGT, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(-1, 0, 32'h8000_0000, WR_TGT, 32'h8000_0000, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(-1, 0, 32'h0, WR_CUR, 32'h0003_0000, 0, 0, 0, 0, 0));
		// Extreme gains, alpha above one, deadband at its top.
		dir_tab.push_back(row(2, 0, 32'h8000_0000, WR_CUR, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(-1, 0, 32'h7FFF_FFFF, WR_CUR, 32'h8000_0000, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(-1, 0, 32'h0, WR_CUR, 32'h0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(-1, OP_CLEAR, 32'h0, 0, 32'h0, 0, 0, 0, 0, 0));

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg_set >= 0) write_set(cfg_sets[dir_tab[i].cfg_set]);
			send_word(dir_tab[i].op, dir_tab[i].fb, dir_tab[i].wr, dir_tab[i].val,
				dir_tab[i].typed, dir_tab[i].res);
		end

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			regs[0] = rnd_gain();
			regs[1] = rnd_gain();
			regs[2] = rnd_gain();
			case (ph % 3)
				0: regs[3] = 32'h1_0000;
				1: regs[3] = (ph == 1) ? 32'h0 : 32'h1_FFFF;
				default: regs[3] = $urandom_range(0, 32'h1_FFFF);
			endcase
			case (ph)
				0: regs[4] = 32'h7FFF_FFFF;
				1: regs[4] = 32'h0;
				default: regs[4] = $urandom_range(0, 32'h0080_0000) | ($urandom & 32'h7F00_0000);
			endcase
			regs[5] = (ph % 2) ? $urandom_range(0, 32'h0000_4000) : $urandom & 32'h7FFF_FFFF;
			if (ph % 2 == 0 && ph > 0) regs[5] = 32'h0;
			regs[6] = (ph == 4) ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0002_0000);
			regs[7] = ph % 4;
			write_set(regs);
			calm = (ph == 3);
			if (ph == 2) hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sp_hint = sp_cur[31:0];
				wr = ($urandom_range(99) < 60) ? 2'd0 : 2'($urandom_range(1, 3));
				send_word($urandom_range(99) < 3, ($urandom_range(3) == 0) ? $urandom :
					sp_hint + rnd_q(32'h0008_0000), wr, rnd_q(32'h0020_0000), 1'b0, '{default: 0});
			end
		end
		calm = 0;
		s_tvalid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Checked %0d result words over %0d register settings, %0d clears,",
			checked, PHASES + 3, clears);
		$display("%0d saturated outputs, with a %0d-cycle output hold-off.", sat_seen,
			HOLD_CYCLES);
		if (errors == 0)
			$display("pid_controller_ramp_deadband regression: pass");
		else
			$display("pid_controller_ramp_deadband regression: fail");
		$finish;
	end

endmodule
